// ----- rtl/ufa_pkg.sv -----
// ----------------------------------------------------------------------------
// ufa_pkg: shared definitions for the received-byte frame assembler
// Sizes, derived widths, command codes, controller states and the result
// record passed to the output register.
// ----------------------------------------------------------------------------
package ufa_pkg;

  // Store sizes
  localparam int unsigned FIFO_DEPTH  = 64;   // 2 .. 1024
  localparam int unsigned FRAME_BYTES = 32;   // 1 .. 64

  // Field widths
  localparam int unsigned CMD_W  = 2;
  localparam int unsigned BYTE_W = 8;
  localparam int unsigned BC_W   = 7;
  localparam int unsigned LVL_W  = 11;

  // Derived widths
  localparam int unsigned FP_W = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
  localparam int unsigned FC_W = $clog2(FIFO_DEPTH + 1);
  localparam int unsigned FA_W = (FRAME_BYTES > 1) ? $clog2(FRAME_BYTES) : 1;
  localparam int unsigned FL_W = $clog2(FRAME_BYTES + 1);

  // Command codes
  typedef enum logic [CMD_W-1:0] {
    CMD_RECV     = 2'd0,
    CMD_COMPLETE = 2'd1,
    CMD_FETCH    = 2'd2,
    CMD_CLEAR    = 2'd3
  } cmd_e;

  // Controller states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CPY,
    ST_FET_RD,
    ST_FET_OUT,
    ST_RESP
  } state_e;

  // One result item
  typedef struct packed {
    logic              status;
    logic [BYTE_W-1:0] data_out;
    logic [BC_W-1:0]   byte_count;
    logic [LVL_W-1:0]  fifo_level;
    logic              frame_ready;
    logic              last;
  } result_t;

endpackage

// ----- rtl/ufa_out_reg.sv -----
// ----------------------------------------------------------------------------
// ufa_out_reg: result output register
// Holds one result until the downstream side takes it; reports when a new
// result may be loaded.
// ----------------------------------------------------------------------------
module ufa_out_reg import ufa_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    push_i,
  input  result_t res_i,
  output logic    free_o,
  output logic    valid_o,
  input  logic    ready_i,
  output result_t res_o
);

  logic    valid_q, valid_d;
  result_t res_q, res_d;

  // Free when empty or being emptied this cycle
  assign free_o = !valid_q || ready_i;

  // Load on push, drop on take
  always_comb begin
    valid_d = valid_q;
    res_d   = res_q;
    if (push_i) begin
      valid_d = 1'b1;
      res_d   = res_i;
    end else if (ready_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    res_q <= res_d;
  end

  assign valid_o = valid_q;
  assign res_o   = res_q;

endmodule

// ----- rtl/uart_rx_fifo_frame_assembler.sv -----
// ----------------------------------------------------------------------------
// uart_rx_fifo_frame_assembler: receive byte FIFO feeding a frame store
// Circular byte FIFO in one memory, assembled frame in a second memory, and
// a small controller that moves bytes between them and streams frames out.
// ----------------------------------------------------------------------------
// One request is handled at a time. Receive, clear, a refused fetch and a
// complete on an empty FIFO give a single result. A complete moves N bytes
// (at most FRAME_BYTES): the FIFO memory is read one byte per cycle, each
// byte being written to the frame memory in the following cycle. A fetch of
// L bytes reads the frame memory through its single registered read port one
// byte at a time, each byte being loaded into the output register before the
// next is read; any stall downstream holds it. The next request is taken once
// the last result of the current one is loaded into the output register.
module uart_rx_fifo_frame_assembler import ufa_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [15:0] s_axis_tdata_i,  // [7:0] data_in, [14:8] max_length
  input  logic [1:0]  s_axis_tuser_i,  // [1:0] cmd
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [31:0] m_axis_tdata_o,  // [7:0] data_out, [14:8] byte_count,
                                       // [25:15] fifo_level, [26] frame_ready
  output logic        m_axis_tuser_o,  // [0] status
  output logic        m_axis_tlast_o   // last
);

  // Memories
  logic [BYTE_W-1:0] fifo_mem  [FIFO_DEPTH];
  logic [BYTE_W-1:0] frame_mem [FRAME_BYTES];
  logic [BYTE_W-1:0] fifo_rd_q, frame_rd_q;

  // Control and pointer state
  state_e          state_q, state_d;
  logic [FP_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [FP_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [FC_W-1:0] count_q, count_d;
  logic [FL_W-1:0] frame_len_q, frame_len_d;
  logic            ready_q, ready_d;
  logic            cpy_pend_q, cpy_pend_d;
  logic [FA_W-1:0] cpy_idx_q, cpy_idx_d;
  logic [BC_W-1:0] fet_len_q, fet_len_d;
  logic [BC_W-1:0] fet_idx_q, fet_idx_d;
  logic            resp_status_q, resp_status_d;
  logic [BC_W-1:0] resp_count_q, resp_count_d;

  // Request fields
  cmd_e              cmd;
  logic [BYTE_W-1:0] data_in;
  logic [BC_W-1:0]   max_length;
  logic              in_acc;

  // Strobes
  logic            fifo_we, fifo_rd_en, frame_rd_en;
  logic            out_push, out_free;
  result_t         out_res, res_o;

  // Derived conditions
  logic            cpy_more, fet_last, fetch_ok;
  logic [BC_W-1:0] frame_len_ext, fetch_len;
  logic [FP_W-1:0] wr_ptr_inc, rd_ptr_inc;

  assign cmd        = cmd_e'(s_axis_tuser_i);
  assign data_in    = s_axis_tdata_i[7:0];
  assign max_length = s_axis_tdata_i[14:8];

  assign s_axis_tready_o = (state_q == ST_IDLE);
  assign in_acc          = s_axis_tvalid_i && s_axis_tready_o;

  assign frame_len_ext = BC_W'(frame_len_q);
  assign fetch_len     = (frame_len_ext < max_length) ? frame_len_ext : max_length;
  assign fetch_ok      = ready_q && (fetch_len != '0);
  assign cpy_more      = (count_q != '0) && (frame_len_q < FL_W'(FRAME_BYTES));
  assign fet_last      = (fet_idx_q + BC_W'(1)) == fet_len_q;

  // Wrap pointers at the FIFO depth
  assign wr_ptr_inc = (wr_ptr_q == FP_W'(FIFO_DEPTH - 1)) ? '0 : wr_ptr_q + FP_W'(1);
  assign rd_ptr_inc = (rd_ptr_q == FP_W'(FIFO_DEPTH - 1)) ? '0 : rd_ptr_q + FP_W'(1);

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          case (cmd)
            CMD_COMPLETE: state_d = (count_q == '0) ? ST_RESP : ST_CPY;
            CMD_FETCH:    state_d = fetch_ok ? ST_FET_RD : ST_RESP;
            default:      state_d = ST_RESP;
          endcase
        end
      end
      ST_CPY: begin
        if (!cpy_more) state_d = ST_RESP;
      end
      ST_FET_RD: state_d = ST_FET_OUT;
      ST_FET_OUT: begin
        if (out_free) state_d = fet_last ? ST_IDLE : ST_FET_RD;
      end
      ST_RESP: begin
        if (out_free) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Datapath updates and strobes
  always_comb begin
    wr_ptr_d      = wr_ptr_q;
    rd_ptr_d      = rd_ptr_q;
    count_d       = count_q;
    frame_len_d   = frame_len_q;
    ready_d       = ready_q;
    cpy_pend_d    = 1'b0;
    cpy_idx_d     = cpy_idx_q;
    fet_len_d     = fet_len_q;
    fet_idx_d     = fet_idx_q;
    resp_status_d = resp_status_q;
    resp_count_d  = resp_count_q;
    fifo_we       = 1'b0;
    fifo_rd_en    = 1'b0;
    frame_rd_en   = 1'b0;
    out_push      = 1'b0;
    out_res       = '0;
    case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          case (cmd)
            CMD_RECV: begin
              // Push unless full; frame-ready drops either way
              ready_d       = 1'b0;
              resp_status_d = 1'b1;
              resp_count_d  = '0;
              if (count_q < FC_W'(FIFO_DEPTH)) begin
                fifo_we       = 1'b1;
                wr_ptr_d      = wr_ptr_inc;
                count_d       = count_q + FC_W'(1);
                resp_status_d = 1'b0;
              end
            end
            CMD_COMPLETE: begin
              if (count_q == '0) begin
                resp_status_d = 1'b1;
                resp_count_d  = frame_len_ext;
              end else begin
                frame_len_d = '0;
              end
            end
            CMD_FETCH: begin
              if (fetch_ok) begin
                ready_d     = 1'b0;
                frame_len_d = '0;
                fet_len_d   = fetch_len;
                fet_idx_d   = '0;
              end else begin
                resp_status_d = 1'b1;
                resp_count_d  = '0;
              end
            end
            default: begin
              // Clear everything
              wr_ptr_d      = '0;
              rd_ptr_d      = '0;
              count_d       = '0;
              frame_len_d   = '0;
              ready_d       = 1'b0;
              resp_status_d = 1'b0;
              resp_count_d  = '0;
            end
          endcase
        end
      end
      ST_CPY: begin
        // Read one FIFO byte a cycle; it is written to the frame next cycle
        if (cpy_more) begin
          fifo_rd_en  = 1'b1;
          rd_ptr_d    = rd_ptr_inc;
          count_d     = count_q - FC_W'(1);
          frame_len_d = frame_len_q + FL_W'(1);
          cpy_pend_d  = 1'b1;
          cpy_idx_d   = frame_len_q[FA_W-1:0];
        end else begin
          ready_d       = 1'b1;
          resp_status_d = 1'b0;
          resp_count_d  = frame_len_ext;
        end
      end
      ST_FET_RD: begin
        frame_rd_en = 1'b1;
      end
      ST_FET_OUT: begin
        if (out_free) begin
          out_push           = 1'b1;
          out_res.data_out   = frame_rd_q;
          out_res.byte_count = fet_len_q;
          out_res.fifo_level = LVL_W'(count_q);
          out_res.last       = fet_last;
          fet_idx_d          = fet_idx_q + BC_W'(1);
        end
      end
      ST_RESP: begin
        if (out_free) begin
          out_push            = 1'b1;
          out_res.status      = resp_status_q;
          out_res.byte_count  = resp_count_q;
          out_res.fifo_level  = LVL_W'(count_q);
          out_res.frame_ready = ready_q;
          out_res.last        = 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      wr_ptr_q    <= '0;
      rd_ptr_q    <= '0;
      count_q     <= '0;
      frame_len_q <= '0;
      ready_q     <= 1'b0;
      cpy_pend_q  <= 1'b0;
    end else begin
      state_q     <= state_d;
      wr_ptr_q    <= wr_ptr_d;
      rd_ptr_q    <= rd_ptr_d;
      count_q     <= count_d;
      frame_len_q <= frame_len_d;
      ready_q     <= ready_d;
      cpy_pend_q  <= cpy_pend_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    cpy_idx_q     <= cpy_idx_d;
    fet_len_q     <= fet_len_d;
    fet_idx_q     <= fet_idx_d;
    resp_status_q <= resp_status_d;
    resp_count_q  <= resp_count_d;
  end

  // FIFO memory: write on receive, registered read during copy
  always_ff @(posedge clk_i) begin
    if (fifo_we) begin
      fifo_mem[wr_ptr_q] <= data_in;
    end
    if (fifo_rd_en) begin
      fifo_rd_q <= fifo_mem[rd_ptr_q];
    end
  end

  // Frame memory: write copied byte, registered read during fetch
  always_ff @(posedge clk_i) begin
    if (cpy_pend_q) begin
      frame_mem[cpy_idx_q] <= fifo_rd_q;
    end
    if (frame_rd_en) begin
      frame_rd_q <= frame_mem[fet_idx_q[FA_W-1:0]];
    end
  end

  // Output register
  ufa_out_reg u_out_reg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (out_push),
    .res_i   (out_res),
    .free_o  (out_free),
    .valid_o (m_axis_tvalid_o),
    .ready_i (m_axis_tready_i),
    .res_o   (res_o)
  );

  assign m_axis_tdata_o = {5'd0, res_o.frame_ready, res_o.fifo_level,
                           res_o.byte_count, res_o.data_out};
  assign m_axis_tuser_o = res_o.status;
  assign m_axis_tlast_o = res_o.last;

endmodule
